>>> rtl/core/fwr_pkg.sv
// Package for the full-weighting restriction unit.
// Holds widths, default sizes, register indexes and the line-store entry type.
// No dependencies.
package fwr_pkg;

  // Default line-store depth in fine samples
  localparam int MAX_ROW_LEN_DEF = 1024;

  // Payload widths
  localparam int VALUE_W = 32;
  localparam int CROW_W  = 12;
  localparam int CCOL_W  = 9;
  localparam int FROW_W  = CROW_W + 1;

  // Vertical sum of three samples weighted 1-2-1, horizontal sum of those
  localparam int VSUM_W  = VALUE_W + 2;
  localparam int HSUM_W  = VALUE_W + 4;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = CROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_COARSE_X_LAST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_Z_LAST = CFG_IDX_W'(1);

  // One line-store entry: the column's samples of fine rows r-1 and r-2
  typedef struct packed {
    logic [VALUE_W-1:0] one_back;
    logic [VALUE_W-1:0] two_back;
  } line_ent_t;

endpackage

>>> rtl/core/full_weighting_restriction_unit.sv
// Full-weighting restriction unit: 2-D 3x3 fine-to-coarse restriction, streaming.
// Depends on fwr_pkg for widths, register indexes and the line-store entry type.
//
// Fine residual samples (signed Q16.16) enter in raster order, one per cycle at
// full rate while in_stall is low; each coarse sample is the 1/4, 1/8, 1/16
// weighted 3x3 window around fine position (2i,2k), floored to Q16.16, and is
// formed through stage 1, stage 2 and the output register from the sample that
// completes its window. The line store is one synchronous memory of
// MAX_FINE_ROW_LEN entries, each holding the two previous fine rows of a
// column, read once and written back once per sample, with a forwarding path
// for single-column grids. The window is formed in two steps: a 1-2-1 column
// sum as the entry returns, then a 1-2-1 sum across three column sums. Writing
// either configuration register restarts the grid at fine position (0,0); the
// line store keeps its contents and needs no clearing after reset. Rows longer
// than the line store are cut to the longest odd length that fits.
module full_weighting_restriction_unit
  import fwr_pkg::*;
#(
  parameter int MAX_FINE_ROW_LEN = MAX_ROW_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // fine sample channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_fine_value,
  // coarse result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_coarse_value,
  output logic [CROW_W-1:0]         out_coarse_row,
  output logic [CCOL_W-1:0]         out_coarse_col,
  output logic                      out_last_of_grid
);

  localparam int AW      = $clog2(MAX_FINE_ROW_LEN);
  localparam int ZMAX    = (MAX_FINE_ROW_LEN - 1) / 2;
  localparam int COL_SAT = 2 * ZMAX;

  // configuration and position
  logic [CROW_W-1:0] cfg_x_last_r;
  logic [CCOL_W-1:0] cfg_z_last_r;
  logic [FROW_W-1:0] row_cnt_r;
  logic [AW-1:0]     col_cnt_r;
  logic [FROW_W-1:0] row_last;
  logic [AW-1:0]     col_last;
  logic              cfg_we;
  logic              in_acc;
  logic              emit;

  // line store
  line_ent_t         mem [MAX_FINE_ROW_LEN];
  line_ent_t         rd_ent_r;
  line_ent_t         fwd_ent_r;
  logic              fwd_r;
  line_ent_t         ent_eff;
  line_ent_t         wr_ent;

  // stage 1: entry returned, column sum
  logic                      s1_valid_r;
  logic signed [VALUE_W-1:0] s1_val_r;
  logic [AW-1:0]             s1_c_r;
  logic                      s1_emit_r;
  logic                      s1_row_odd_r;
  logic                      s1_one_zero_r;
  logic                      s1_two_zero_r;
  logic                      s1_col0_r;
  logic                      s1_col_odd_r;
  logic                      s1_last_r;
  logic [CROW_W-1:0]         s1_crow_r;
  logic [CCOL_W-1:0]         s1_ccol_r;
  logic signed [VSUM_W-1:0]  vsum;
  logic                      s1_adv;

  // stage 2: three column sums, horizontal sum
  logic                      s2_valid_r;
  logic signed [VSUM_W-1:0]  v0_r;
  logic signed [VSUM_W-1:0]  v1_r;
  logic signed [VSUM_W-1:0]  v2_r;
  logic                      s2_col_odd_r;
  logic                      s2_last_r;
  logic [CROW_W-1:0]         s2_crow_r;
  logic [CCOL_W-1:0]         s2_ccol_r;
  logic signed [HSUM_W-1:0]  hsum;
  logic                      s2_adv;
  logic                      s2_free;
  logic                      out_free;

  // output register
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [CROW_W-1:0]         out_row_r;
  logic [CCOL_W-1:0]         out_col_r;
  logic                      out_last_r;

  // grid limits, row length saturated to the line store
  always_comb begin
    row_last = {cfg_x_last_r, 1'b0};
    if (int'(cfg_z_last_r) > ZMAX) begin
      col_last = AW'(COL_SAT);
    end else begin
      col_last = AW'({cfg_z_last_r, 1'b0});
    end
  end

  // handshake and pipeline flow
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_adv    = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_stall  = s1_valid_r && !s2_free;
  assign in_acc    = in_valid && !in_stall;

  // a window completes on an odd or last row and an odd or last column
  assign emit = (row_cnt_r[0] || (row_cnt_r == row_last)) &&
                (col_cnt_r[0] || (col_cnt_r == col_last));

  // entry as seen by stage 1, with the write of the previous sample forwarded
  always_comb begin
    ent_eff         = fwd_r ? fwd_ent_r : rd_ent_r;
    wr_ent.one_back = s1_val_r;
    wr_ent.two_back = ent_eff.one_back;
  end

  // column sum: rows r-2, r-1, r weighted 1-2-1 on odd rows, rows r-1, r as 1-2
  always_comb begin
    logic signed [VALUE_W-1:0] one_s;
    logic signed [VALUE_W-1:0] two_s;
    logic signed [VSUM_W-1:0]  one_e;
    logic signed [VSUM_W-1:0]  two_e;
    logic signed [VSUM_W-1:0]  cur_e;
    one_s = s1_one_zero_r ? '0 : signed'(ent_eff.one_back);
    two_s = s1_two_zero_r ? '0 : signed'(ent_eff.two_back);
    one_e = VSUM_W'(one_s);
    two_e = VSUM_W'(two_s);
    cur_e = VSUM_W'(s1_val_r);
    if (s1_row_odd_r) begin
      vsum = two_e + (one_e <<< 1) + cur_e;
    end else begin
      vsum = one_e + (cur_e <<< 1);
    end
  end

  // horizontal sum over columns c-2, c-1, c in sixteenths
  always_comb begin
    logic signed [HSUM_W-1:0] h0;
    logic signed [HSUM_W-1:0] h1;
    logic signed [HSUM_W-1:0] h2;
    h0 = HSUM_W'(v0_r);
    h1 = HSUM_W'(v1_r);
    h2 = HSUM_W'(v2_r);
    if (s2_col_odd_r) begin
      hsum = h2 + (h1 <<< 1) + h0;
    end else begin
      hsum = h1 + (h0 <<< 1);
    end
  end

  // line store: read on accept, write back as stage 1 moves on
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_c_r] <= wr_ent;
    end
    if (in_acc) begin
      rd_ent_r <= mem[col_cnt_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_x_last_r <= '0;
      cfg_z_last_r <= '0;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // a write to either configuration register restarts the grid
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COARSE_X_LAST: begin
            cfg_x_last_r <= cfg_data[CROW_W-1:0];
            row_cnt_r    <= '0;
            col_cnt_r    <= '0;
          end
          REG_COARSE_Z_LAST: begin
            cfg_z_last_r <= cfg_data[CCOL_W-1:0];
            row_cnt_r    <= '0;
            col_cnt_r    <= '0;
          end
          default: begin
          end
        endcase
      end else if (in_acc) begin
        if (col_cnt_r >= col_last) begin
          col_cnt_r <= '0;
          if (row_cnt_r >= row_last) begin
            row_cnt_r <= '0;
          end else begin
            row_cnt_r <= row_cnt_r + FROW_W'(1);
          end
        end else begin
          col_cnt_r <= col_cnt_r + AW'(1);
        end
      end

      // stage valids
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= s1_emit_r;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // stage 1 load
    if (in_acc) begin
      s1_val_r      <= in_fine_value;
      s1_c_r        <= col_cnt_r;
      s1_emit_r     <= emit;
      s1_row_odd_r  <= row_cnt_r[0];
      s1_one_zero_r <= (row_cnt_r == '0);
      s1_two_zero_r <= (row_cnt_r[FROW_W-1:1] == '0);
      s1_col0_r     <= (col_cnt_r == '0);
      s1_col_odd_r  <= col_cnt_r[0];
      s1_last_r     <= (row_cnt_r == row_last) && (col_cnt_r == col_last);
      s1_crow_r     <= row_cnt_r[FROW_W-1:1];
      s1_ccol_r     <= CCOL_W'(col_cnt_r >> 1);
      fwd_r         <= s1_adv && (s1_c_r == col_cnt_r);
      fwd_ent_r     <= wr_ent;
    end

    // column sums shift along; a new row starts with empty left columns
    if (s1_adv) begin
      v0_r <= vsum;
      if (s1_col0_r) begin
        v1_r <= '0;
        v2_r <= '0;
      end else begin
        v1_r <= v0_r;
        v2_r <= v1_r;
      end
      s2_col_odd_r <= s1_col_odd_r;
      s2_last_r    <= s1_last_r;
      s2_crow_r    <= s1_crow_r;
      s2_ccol_r    <= s1_ccol_r;
    end

    // floor of sixteenths by arithmetic shift
    if (s2_adv) begin
      out_value_r <= hsum[HSUM_W-1:4];
      out_row_r   <= s2_crow_r;
      out_col_r   <= s2_ccol_r;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coarse_value = out_value_r;
  assign out_coarse_row   = out_row_r;
  assign out_coarse_col   = out_col_r;
  assign out_last_of_grid = out_last_r;

endmodule

>>> sim/tb_full_weighting_restriction_unit.sv
// Testbench for full_weighting_restriction_unit: directed table, then randomised grids.
// Needs fwr_pkg and the unit itself; expected coarse samples come from the table
// for typed rows, else from a line-store predictor fed every accepted fine sample.
`timescale 1ns / 100ps

module tb_full_weighting_restriction_unit;
  import fwr_pkg::*;

  localparam int ROW_LEN        = MAX_ROW_LEN_DEF;
  localparam int SETTLE_CYCLES  = 10;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int RANDOM_PHASES  = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CROW_W-1:0]  row;
    logic [CCOL_W-1:0]  col;
    logic               last;
  } coarse_t;

  typedef enum bit {STEP_REG, STEP_SAMPLE} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [VALUE_W-1:0]   value;
    bit                   typed;
    coarse_t              want;
  } step_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [VALUE_W-1:0]    in_fine_value = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [VALUE_W-1:0]    out_coarse_value;
  logic [CROW_W-1:0]     out_coarse_row;
  logic [CCOL_W-1:0]     out_coarse_col;
  logic                  out_last_of_grid;

  // Predictor state: registers, line stores, current-row taps, position
  logic [CROW_W-1:0]  x_last_reg = '0;
  logic [CCOL_W-1:0]  z_last_reg = '0;
  logic [VALUE_W-1:0] line_one_back [ROW_LEN];
  logic [VALUE_W-1:0] line_two_back [ROW_LEN];
  logic [VALUE_W-1:0] recent_fine [2];
  int                 fine_row = 0;
  int                 fine_col = 0;

  coarse_t     coarse_expected_q[$];
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  full_weighting_restriction_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_fine_value    (in_fine_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coarse_value (out_coarse_value),
    .out_coarse_row   (out_coarse_row),
    .out_coarse_col   (out_coarse_col),
    .out_last_of_grid (out_last_of_grid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One tap of the 3x3 window; zero outside the grid or not yet seen
  function automatic longint window_tap(int rr, int cc, int r, int c, int rlast, int clast,
                                        logic [VALUE_W-1:0] cur);
    logic [VALUE_W-1:0] bits;
    if (rr < 0 || rr > rlast || cc < 0 || cc > clast || cc > c) return 0;
    if (rr == r) begin
      if (cc == c) bits = cur;
      else if (cc == c - 1) bits = recent_fine[0];
      else if (cc == c - 2) bits = recent_fine[1];
      else return 0;
    end else if (cc >= ROW_LEN) begin
      return 0;
    end else if (rr == r - 1) begin
      bits = line_one_back[cc];
    end else if (rr == r - 2) begin
      bits = line_two_back[cc];
    end else begin
      return 0;
    end
    return longint'($signed(bits));
  endfunction

  function automatic void shift_line(int col, logic [VALUE_W-1:0] bits);
    if (col < 0 || col >= ROW_LEN) return;
    line_two_back[col] = line_one_back[col];
    line_one_back[col] = bits;
  endfunction

  // Advance the predictor by one fine sample; returns 1 when a coarse sample completes
  function automatic bit restrict_sample(input logic [VALUE_W-1:0] cur, output coarse_t res);
    int     rlast, clast, zeff, r, c, rc, cc;
    longint acc;
    bit     hit;
    zeff = int'(z_last_reg);
    if (2 * zeff + 1 > ROW_LEN) zeff = (ROW_LEN - 1) / 2;
    rlast = 2 * int'(x_last_reg);
    clast = 2 * zeff;
    r = fine_row;
    c = fine_col;
    hit = (r % 2 == 1 || r == rlast) && (c % 2 == 1 || c == clast);
    res = '0;
    if (hit) begin
      rc = r - r % 2;
      cc = c - c % 2;
      acc = 0;
      // weights in sixteenths: centre 4, faces 2, corners 1
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++)
          acc += (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1) *
                 window_tap(rc + dr, cc + dc, r, c, rlast, clast, cur);
      res.value = VALUE_W'(acc >>> 4);
      res.row   = CROW_W'(rc / 2);
      res.col   = CCOL_W'(cc / 2);
      res.last  = (r == rlast && c == clast);
    end
    // line stores lag two columns; the row tail goes in at the row's end
    if (c >= 2) shift_line(c - 2, recent_fine[1]);
    if (c == clast) begin
      if (c >= 1) shift_line(c - 1, recent_fine[0]);
      shift_line(c, cur);
    end
    recent_fine[1] = recent_fine[0];
    recent_fine[0] = cur;
    if (c >= clast) begin
      fine_col = 0;
      recent_fine[0] = '0;
      recent_fine[1] = '0;
      fine_row = (r >= rlast) ? 0 : r + 1;
    end else begin
      fine_col = c + 1;
    end
    return hit;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{kind: STEP_REG, idx: idx, data: data, value: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  // Typed rows are 1x1 grids, so the result always sits at (0,0) and is last
  function automatic step_t sample_row(logic [VALUE_W-1:0] v, bit typed,
                                       logic [VALUE_W-1:0] w);
    step_t s;
    s = '{kind: STEP_SAMPLE, idx: '0, data: '0, value: v, typed: typed,
          want: '{value: w, row: '0, col: '0, last: 1'b1}};
    return s;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_fine();
    case ($urandom_range(7))
      0:       return {1'b0, {(VALUE_W-1){1'b1}}};
      1:       return {1'b1, {(VALUE_W-1){1'b0}}};
      2:       return VALUE_W'(int'($urandom_range(32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // Hold the input idle until every expected result is out and the pipe has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (coarse_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COARSE_X_LAST: x_last_reg = val[CROW_W-1:0];
      REG_COARSE_Z_LAST: z_last_reg = val[CCOL_W-1:0];
      default: ;
    endcase
    // either register restarts the grid; line stores are kept
    if (idx == REG_COARSE_X_LAST || idx == REG_COARSE_Z_LAST) begin
      fine_row = 0;
      fine_col = 0;
      recent_fine[0] = '0;
      recent_fine[1] = '0;
    end
  endtask

  // Offer one fine sample, with a random gap in front; predict once it is taken
  task automatic put_sample(input logic [VALUE_W-1:0] v, input bit typed, input coarse_t want);
    coarse_t got;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_fine_value <= v;
    do @(posedge clk); while (in_stall);
    if (restrict_sample(v, got)) coarse_expected_q.push_back(typed ? want : got);
  endtask

  // Receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    coarse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (coarse_expected_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: value %h row %0d col %0d last %b",
                   out_coarse_value, out_coarse_row, out_coarse_col, out_last_of_grid);
      end else begin
        want = coarse_expected_q.pop_front();
        if (out_coarse_value !== want.value || out_coarse_row !== want.row ||
            out_coarse_col !== want.col || out_last_of_grid !== want.last) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected %h (%0d,%0d) last %b, got %h (%0d,%0d) last %b",
                     want.value, want.row, want.col, want.last, out_coarse_value,
                     out_coarse_row, out_coarse_col, out_last_of_grid);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("full_weighting_restriction_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    step_t       plan[$];
    int unsigned gx, gz, cells, total;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // 1x1 grid after reset: result is the sample floored by four
    plan.push_back(sample_row(32'h0000_0000, 1'b1, 32'h0000_0000));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b1, 32'h1FFF_FFFF));
    plan.push_back(sample_row(32'h8000_0000, 1'b1, 32'hE000_0000));
    plan.push_back(sample_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    plan.push_back(sample_row(32'h0000_0003, 1'b1, 32'h0000_0000));
    plan.push_back(sample_row(32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF));
    plan.push_back(sample_row(32'h0001_0000, 1'b1, 32'h0000_4000));
    plan.push_back(sample_row(32'hAAAA_AAAA, 1'b1, 32'hEAAA_AAAA));
    plan.push_back(sample_row(32'h5555_5555, 1'b1, 32'h1555_5555));
    // single row of three, all at the positive extreme
    plan.push_back(reg_row(REG_COARSE_Z_LAST, 12'd1));
    repeat (3) plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
    // single column of three at the negative extreme; a write to an unused
    // index mid-grid must leave the position alone
    plan.push_back(reg_row(REG_COARSE_X_LAST, 12'd1));
    plan.push_back(reg_row(REG_COARSE_Z_LAST, 12'd0));
    plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_UNMAPPED, 12'hFFF));
    repeat (2) plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    // 3x3 grid; upper data bits of the column register are dropped
    plan.push_back(reg_row(REG_COARSE_Z_LAST, 12'hE01));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(sample_row(32'h0000_0001, 1'b0, '0));
    plan.push_back(sample_row(32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
    plan.push_back(sample_row(32'h8000_0000, 1'b0, '0));
    plan.push_back(sample_row(32'h0000_0000, 1'b0, '0));
    plan.push_back(sample_row(32'h1234_5678, 1'b0, '0));
    plan.push_back(sample_row(32'hDEAD_BEEF, 1'b0, '0));

    foreach (plan[n]) begin
      if (plan[n].kind == STEP_REG) write_reg(plan[n].idx, plan[n].data);
      else put_sample(plan[n].value, plan[n].typed, plan[n].want);
    end

    // Random grids: largest sizes first, then a few small ones
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin gx = 4095; gz = 0;   end
        1: begin gx = 0;    gz = 511; end
        default: begin
          gx = (ph % 3 == 0) ? $urandom_range(1) : $urandom_range(4);
          gz = (ph % 3 == 0) ? $urandom_range(60, 13) : $urandom_range(12);
        end
      endcase
      if (ph % 2 == 0) begin
        write_reg(REG_COARSE_X_LAST, CFG_DATA_W'(gx));
        write_reg(REG_COARSE_Z_LAST, CFG_DATA_W'(gz));
      end else begin
        write_reg(REG_COARSE_Z_LAST, CFG_DATA_W'(gz));
        write_reg(REG_COARSE_X_LAST, CFG_DATA_W'(gx));
      end
      cells = (2 * gx + 1) * (2 * gz + 1);
      if (ph == 0) total = 60;
      else if (cells >= 70) total = cells;
      else total = cells * (70 / cells);
      // odd phases after phase 1 end on a broken grid
      if (ph > 1 && ph % 2 == 1 && cells > 1) total += $urandom_range(cells - 1, 1);

      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 70; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 70; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase

      for (int unsigned n = 0; n < total; n++) begin
        if (n == total / 2) wait_idle();
        put_sample(pick_fine(), 1'b0, '0);
      end
    end

    wait_idle();
    if (bad_results == 0 && coarse_expected_q.size() == 0)
      $display("full_weighting_restriction_unit verification clean");
    else
      $display("full_weighting_restriction_unit verification failed");
    $finish;
  end

endmodule
